@@ src/utf8_entity_text_to_ascii_top_macros.svh @@
// assertion macros for the utf8 entity text to ascii block
// used by the top level; expects aclk and aresetn in scope
`ifndef UTF8_ENTITY_TEXT_TO_ASCII_TOP_MACROS_SVH
`define UTF8_ENTITY_TEXT_TO_ASCII_TOP_MACROS_SVH

// same-cycle implication
`define U8E_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define U8E_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/u8e_pkg.sv @@
// shared types, constants and code point table for the text to ascii block
// no dependencies
package u8e_pkg;

    localparam int ENT_LOOKAHEAD = 6;
    localparam int ENT_NUM       = 7;
    localparam int ENT_BUF       = ENT_LOOKAHEAD - 2;
    localparam int OP_SLOTS      = 6;
    localparam int PKT_SLOTS     = 7;
    localparam int Q_DEPTH       = 4;
    localparam int CFG_W         = 13;
    localparam int CNT_W         = 12;

    typedef logic [6:0] ch_t;

    // one character operation produced by the classifier
    typedef struct packed {
        logic valid;
        logic space;
        logic text;
        ch_t  ch;
    } op_t;

    // one packet of result characters for one accepted byte
    typedef struct packed {
        logic [2:0]               cnt;
        logic                     last;
        ch_t [PKT_SLOTS-1:0]      ch;
    } pkt_t;

    localparam ch_t CH_SPACE = 7'h20;
    localparam ch_t CH_QMARK = 7'h3F;
    localparam ch_t CH_AMP   = 7'h26;
    localparam ch_t CH_DOT   = 7'h2E;
    localparam ch_t CH_NUL   = 7'h00;

    // special codes out of the code point map
    localparam ch_t MAP_SPACE    = 7'h00;
    localparam ch_t MAP_ELLIPSIS = 7'h01;

    // entity texts, left aligned, byte i at [47-8*i -: 8]
    localparam logic [8*ENT_LOOKAHEAD-1:0] ENT_TEXT [ENT_NUM] = '{
        "&quot;", {"&amp;", 8'h00}, {"&lt;", 16'h0000}, {"&gt;", 16'h0000},
        "&#039;", {"&#39;", 8'h00}, "&apos;"
    };
    localparam logic [2:0] ENT_LEN [ENT_NUM] = '{
        3'd6, 3'd5, 3'd4, 3'd4, 3'd6, 3'd5, 3'd6
    };
    localparam ch_t ENT_CHAR [ENT_NUM] = '{
        7'h22, 7'h26, 7'h3C, 7'h3E, 7'h27, 7'h27, 7'h27
    };

    // code point to ascii look-alike
    function automatic ch_t map_cp(input logic [20:0] cp);
        ch_t r;
        unique case (cp)
            21'h2018, 21'h2019, 21'h201B, 21'h2032: r = 7'h27;
            21'h201C, 21'h201D, 21'h2033:           r = 7'h22;
            21'h2010, 21'h2011, 21'h2012, 21'h2013,
            21'h2014, 21'h2015, 21'h2212:           r = 7'h2D;
            21'h2026:                               r = MAP_ELLIPSIS;
            21'h00A0, 21'h2009, 21'h200A, 21'h202F: r = MAP_SPACE;
            21'h00E9, 21'h00E8, 21'h00EA, 21'h00EB: r = 7'h65;
            21'h00E1, 21'h00E0, 21'h00E2, 21'h00E4,
            21'h00E3, 21'h00E5:                     r = 7'h61;
            21'h00ED, 21'h00EC, 21'h00EE, 21'h00EF: r = 7'h69;
            21'h00F3, 21'h00F2, 21'h00F4, 21'h00F6,
            21'h00F5:                               r = 7'h6F;
            21'h00FA, 21'h00F9, 21'h00FB, 21'h00FC: r = 7'h75;
            21'h00F1:                               r = 7'h6E;
            21'h00E7:                               r = 7'h63;
            default:                                r = CH_QMARK;
        endcase
        return r;
    endfunction

endpackage

@@ src/utf8_entity_text_to_ascii_top.sv @@
// Text to printable ASCII: takes one source byte per cycle while s_ready is high and gives
// at most one result character per cycle. A byte that yields no character (entity or UTF-8
// prefix bytes) is taken at the input only; a byte that yields several characters (a flushed
// entity, an ellipsis, a released space) sends them one character per output transaction, up
// to seven. A four-packet queue between the classifier and the output serializer lets input
// continue while earlier characters drain; s_ready drops only when that queue is full.
// Top level: instantiates u8e_front, u8e_queue and u8e_back; uses u8e_pkg and the macros header
`include "utf8_entity_text_to_ascii_top_macros.svh"

module utf8_entity_text_to_ascii_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [u8e_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_in_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [6:0]                m_out_byte,
    output logic                      m_out_last
);
    import u8e_pkg::*;

    logic q_full;
    logic q_push;
    pkt_t q_pkt;
    logic q_pop;
    logic q_empty;
    pkt_t q_head;
    logic out_printable;
    logic term_in;

    // classifier
    u8e_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_pkt       (q_pkt)
    );

    // packet queue
    u8e_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_pkt (q_pkt),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_pkt (q_head)
    );

    // output serializer
    u8e_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    // terms used by the checks
    assign out_printable = (m_out_byte >= 7'h20) && (m_out_byte <= 7'h7E);
    assign term_in       = s_valid && s_ready && (s_in_byte == 8'h00);

    // checks
    `U8E_ASSERT_IMP(a_last_is_zero, m_valid && m_out_last, m_out_byte == 7'h00, "last not zero")
    `U8E_ASSERT_IMP(a_printable, m_valid && !m_out_last, out_printable, "unprintable output")
    `U8E_ASSERT_NXT(a_term_queued, term_in, m_valid, "terminator lost")

endmodule

@@ src/u8e_front.sv @@
// front end: accepts source bytes, tracks utf-8, entity and spacing state,
// and builds at most one packet of result characters per byte; uses u8e_pkg
module u8e_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [u8e_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_in_byte,
    input  logic                      q_full,
    output logic                      q_push,
    output u8e_pkg::pkt_t             q_pkt
);
    import u8e_pkg::*;

    typedef struct packed {
        op_t         op;
        logic        ent_start;
        logic        lead;
        logic [1:0]  extra;
        logic [20:0] acc;
    } disp_t;

    logic [CNT_W-1:0]  lim_reg, lim_next;
    logic              prev_reg, prev_next;
    logic [CNT_W-1:0]  wc_reg, wc_next;
    logic              held_reg, held_next;
    logic [20:0]       acc_reg, acc_next;
    logic [1:0]        cont_reg, cont_next;
    logic [2:0]        fill_reg, fill_next;
    logic [ENT_NUM-1:0] mask_reg, mask_next;
    ch_t               ent_bytes_reg [ENT_BUF];
    logic              ent_wr;
    logic [1:0]        ent_wr_idx;
    logic              accept;

    // byte classifier for a byte outside any sequence or entity
    function automatic disp_t dispatch(input logic [7:0] c);
        disp_t d;
        d = '0;
        if (c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09) begin
            d.op.valid = 1'b1;
            d.op.space = 1'b1;
        end else if (c == 8'h26) begin
            d.ent_start = 1'b1;
        end else if (c >= 8'h20 && c < 8'h7F) begin
            d.op.valid = 1'b1;
            d.op.text  = 1'b1;
            d.op.ch    = c[6:0];
        end else if (c >= 8'hC0) begin
            d.lead  = 1'b1;
            d.extra = (c >= 8'hF0) ? 2'd3 : ((c >= 8'hE0) ? 2'd2 : 2'd1);
            d.acc   = {15'd0, c[5:0] & (6'h3F >> d.extra)};
        end else begin
            d.op.valid = 1'b1;
            d.op.text  = 1'b1;
            d.op.ch    = CH_QMARK;
        end
        return d;
    endfunction

    // operations for one mapped code point
    function automatic op_t [2:0] map_ops(input logic [20:0] cp);
        op_t [2:0] o;
        ch_t       m;
        o = '0;
        m = map_cp(cp);
        if (m == MAP_SPACE) begin
            o[0].valid = 1'b1;
            o[0].space = 1'b1;
        end else if (m == MAP_ELLIPSIS) begin
            o[0] = '{valid: 1'b1, space: 1'b0, text: 1'b0, ch: CH_DOT};
            o[1] = '{valid: 1'b1, space: 1'b0, text: 1'b0, ch: CH_DOT};
            o[2] = '{valid: 1'b1, space: 1'b0, text: 1'b1, ch: CH_DOT};
        end else begin
            o[0] = '{valid: 1'b1, space: 1'b0, text: 1'b1, ch: m};
        end
        return o;
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // capacity limit as the highest character count still writable
    always_comb begin
        lim_next = lim_reg;
        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                lim_next = '0;
            end else if (cfg_wr_data > CFG_W'(4096)) begin
                lim_next = CNT_W'(4095);
            end else begin
                lim_next = CNT_W'(cfg_wr_data - CFG_W'(1));
            end
        end
    end

    // classify the byte and turn its operations into a packet
    always_comb begin
        op_t              ops [OP_SLOTS];
        op_t [2:0]        mo;
        disp_t            d;
        logic             do_disp;
        logic [ENT_NUM-1:0] match;
        logic             complete;
        ch_t              comp_ch;
        logic             p;
        logic             h;
        logic [CNT_W-1:0] w;
        logic [2:0]       idx;

        for (int i = 0; i < OP_SLOTS; i++) ops[i] = '0;
        mo         = '0;
        d          = dispatch(s_in_byte);
        do_disp    = 1'b0;
        match      = '0;
        complete   = 1'b0;
        comp_ch    = CH_NUL;
        acc_next   = acc_reg;
        cont_next  = cont_reg;
        fill_next  = fill_reg;
        mask_next  = mask_reg;
        ent_wr     = 1'b0;
        ent_wr_idx = fill_reg[1:0] - 2'd1;

        // entity candidates that still match with this byte
        for (int k = ENT_NUM - 1; k >= 0; k--) begin
            match[k] = mask_reg[k] && ((fill_reg + 3'd1) <= ENT_LEN[k]) &&
                       (ENT_TEXT[k][(47 - 8 * fill_reg) -: 8] == s_in_byte);
            if (match[k] && (fill_reg + 3'd1) == ENT_LEN[k]) begin
                complete = 1'b1;
                comp_ch  = ENT_CHAR[k];
            end
        end

        if (s_in_byte == 8'h00) begin
            if (cont_reg != 2'd0) begin
                mo = map_ops(acc_reg);
                for (int i = 0; i < 3; i++) ops[i] = mo[i];
            end
            if (fill_reg != 3'd0) begin
                ops[0] = '{valid: 1'b1, space: 1'b0, text: 1'b1, ch: CH_AMP};
                for (int i = 1; i < ENT_BUF + 1; i++) begin
                    ops[i] = '{valid: (3'(i) < fill_reg), space: 1'b0, text: 1'b1,
                               ch: ent_bytes_reg[i-1]};
                end
            end
        end else if (cont_reg != 2'd0) begin
            if (s_in_byte[7:6] == 2'b10) begin
                acc_next  = {acc_reg[14:0], s_in_byte[5:0]};
                cont_next = cont_reg - 2'd1;
                if (cont_reg == 2'd1) begin
                    mo = map_ops(acc_next);
                    for (int i = 0; i < 3; i++) ops[i] = mo[i];
                end
            end else begin
                cont_next = 2'd0;
                mo = map_ops(acc_reg);
                for (int i = 0; i < 3; i++) ops[i] = mo[i];
                do_disp = 1'b1;
            end
        end else if (fill_reg != 3'd0) begin
            if (complete) begin
                ops[OP_SLOTS-1] = '{valid: 1'b1, space: 1'b0, text: 1'b1, ch: comp_ch};
                fill_next = 3'd0;
            end else if (match != '0) begin
                ent_wr    = 1'b1;
                fill_next = fill_reg + 3'd1;
                mask_next = match;
            end else begin
                ops[0] = '{valid: 1'b1, space: 1'b0, text: 1'b1, ch: CH_AMP};
                for (int i = 1; i < ENT_BUF + 1; i++) begin
                    ops[i] = '{valid: (3'(i) < fill_reg), space: 1'b0, text: 1'b1,
                               ch: ent_bytes_reg[i-1]};
                end
                fill_next = 3'd0;
                do_disp   = 1'b1;
            end
        end else begin
            do_disp = 1'b1;
        end

        // dispatch of the byte itself goes last
        if (do_disp) begin
            ops[OP_SLOTS-1] = d.op;
            if (d.ent_start) begin
                fill_next = 3'd1;
                mask_next = '1;
            end
            if (d.lead) begin
                acc_next  = d.acc;
                cont_next = d.extra;
            end
        end

        // apply operations in order against spacing and capacity
        p     = prev_reg;
        h     = held_reg;
        w     = wc_reg;
        idx   = 3'd0;
        q_pkt = '0;
        for (int i = 0; i < OP_SLOTS; i++) begin
            if (ops[i].valid) begin
                if (ops[i].space) begin
                    if (!p && w < lim_reg) begin
                        h = 1'b1;
                        w = w + CNT_W'(1);
                    end
                    p = 1'b1;
                end else begin
                    if (w < lim_reg) begin
                        if (h) begin
                            q_pkt.ch[idx] = CH_SPACE;
                            idx = idx + 3'd1;
                            h = 1'b0;
                        end
                        q_pkt.ch[idx] = ops[i].ch;
                        idx = idx + 3'd1;
                        w = w + CNT_W'(1);
                    end
                    if (ops[i].text) p = 1'b0;
                end
            end
        end

        prev_next = p;
        held_next = h;
        wc_next   = w;

        // terminator and string reset
        if (s_in_byte == 8'h00) begin
            q_pkt.ch[idx] = CH_NUL;
            idx        = idx + 3'd1;
            q_pkt.last = 1'b1;
            prev_next  = 1'b1;
            held_next  = 1'b0;
            wc_next    = '0;
            acc_next   = '0;
            cont_next  = 2'd0;
            fill_next  = 3'd0;
        end
        q_pkt.cnt = idx;
        q_push    = accept && (idx != 3'd0);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg  <= CNT_W'(255);
            prev_reg <= 1'b1;
            wc_reg   <= '0;
            held_reg <= 1'b0;
            acc_reg  <= '0;
            cont_reg <= 2'd0;
            fill_reg <= 3'd0;
            mask_reg <= '0;
        end else begin
            lim_reg <= lim_next;
            if (accept) begin
                prev_reg <= prev_next;
                wc_reg   <= wc_next;
                held_reg <= held_next;
                acc_reg  <= acc_next;
                cont_reg <= cont_next;
                fill_reg <= fill_next;
                mask_reg <= mask_next;
            end
        end
    end

    // pending entity bytes after the ampersand
    always_ff @(posedge aclk) begin
        if (accept && ent_wr) begin
            ent_bytes_reg[ent_wr_idx] <= s_in_byte[6:0];
        end
    end

endmodule

@@ src/u8e_queue.sv @@
// short packet queue between the front end and the output serializer
// uses u8e_pkg
module u8e_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  u8e_pkg::pkt_t push_pkt,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output u8e_pkg::pkt_t head_pkt
);
    import u8e_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    pkt_t             mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_pkt = mem_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // packet storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule

@@ src/u8e_back.sv @@
// back end: sends the characters of the head packet one transaction at a time
// uses u8e_pkg
module u8e_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  u8e_pkg::pkt_t q_head,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [6:0]    m_out_byte,
    output logic          m_out_last
);
    import u8e_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       at_end;

    assign at_end     = (idx_reg == q_head.cnt - 3'd1);
    assign m_valid    = !q_empty;
    assign m_out_byte = q_head.ch[idx_reg];
    assign m_out_last = q_head.last && at_end;
    assign q_pop      = m_valid && m_ready && at_end;

    // position within the head packet
    always_comb begin
        idx_next = idx_reg;
        if (m_valid && m_ready) begin
            idx_next = at_end ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 3'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

@@ tb/sv/text_ascii_checker.sv @@
// checker for the utf8 entity text to ascii block: watches both channels,
// predicts every output character and compares it; depends on nothing else
module text_ascii_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [6:0]  m_out_byte,
    input  logic        m_out_last,
    output int          fail_count,
    output int          pending,
    output int          chars_seen
);

    // expected characters, {last, char}
    logic [7:0] expected_chars[$];

    // predictor copy of the register and the per-string state
    logic [12:0] max_len;
    logic        after_space;
    int          committed;
    logic        space_held;
    logic [20:0] cp_acc;
    int          cont_left;
    logic [7:0]  ent_buf[6];
    int          ent_fill;

    string      ent_names[7] = '{"&quot;", "&amp;", "&lt;", "&gt;", "&#039;", "&#39;", "&apos;"};
    logic [6:0] ent_chars[7] = '{7'h22, 7'h26, 7'h3C, 7'h3E, 7'h27, 7'h27, 7'h27};

    assign pending = expected_chars.size();

    function automatic int clamp_len();
        int c;
        c = max_len;
        if (c > 4096) c = 4096;
        if (c < 1) c = 1;
        return c;
    endfunction

    task automatic push_char(input logic [6:0] c, input logic last);
        if (expected_chars.size() < 100000) expected_chars.push_back({last, c});
    endtask

    task automatic write_char(input logic [6:0] c);
        if (committed + 1 < clamp_len()) begin
            if (space_held) begin
                push_char(7'h20, 1'b0);
                space_held = 1'b0;
            end
            push_char(c, 1'b0);
            committed++;
        end
    endtask

    task automatic write_text(input logic [6:0] c);
        write_char(c);
        after_space = 1'b0;
    endtask

    task automatic write_space();
        if (!after_space && committed + 1 < clamp_len()) begin
            space_held = 1'b1;
            committed++;
        end
        after_space = 1'b1;
    endtask

    // code point to look-alike character
    task automatic map_code_point(input logic [20:0] cp);
        case (cp)
            21'h2018, 21'h2019, 21'h201B, 21'h2032: write_text(7'h27);
            21'h201C, 21'h201D, 21'h2033: write_text(7'h22);
            21'h2010, 21'h2011, 21'h2012, 21'h2013,
            21'h2014, 21'h2015, 21'h2212: write_text(7'h2D);
            21'h2026: begin
                write_char(7'h2E);
                write_char(7'h2E);
                write_text(7'h2E);
            end
            21'h00A0, 21'h2009, 21'h200A, 21'h202F: write_space();
            21'h00E9, 21'h00E8, 21'h00EA, 21'h00EB: write_text(7'h65);
            21'h00E1, 21'h00E0, 21'h00E2, 21'h00E4,
            21'h00E3, 21'h00E5: write_text(7'h61);
            21'h00ED, 21'h00EC, 21'h00EE, 21'h00EF: write_text(7'h69);
            21'h00F3, 21'h00F2, 21'h00F4, 21'h00F6,
            21'h00F5: write_text(7'h6F);
            21'h00FA, 21'h00F9, 21'h00FB, 21'h00FC: write_text(7'h75);
            21'h00F1: write_text(7'h6E);
            21'h00E7: write_text(7'h63);
            default: write_text(7'h3F);
        endcase
    endtask

    task automatic flush_entity();
        write_text(7'h26);
        for (int i = 1; i < ent_fill && i < 6; i++) write_text(ent_buf[i][6:0]);
        ent_fill = 0;
    endtask

    task automatic plain_byte(input logic [7:0] c);
        int extra;
        if (c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09) begin
            write_space();
        end else if (c == 8'h26) begin
            ent_buf[0] = 8'h26;
            ent_fill = 1;
        end else if (c >= 8'h20 && c < 8'h7F) begin
            write_text(c[6:0]);
        end else if (c >= 8'hC0) begin
            extra = (c >= 8'hF0) ? 3 : ((c >= 8'hE0) ? 2 : 1);
            cp_acc = c & (8'h3F >> extra);
            cont_left = extra;
        end else begin
            write_text(7'h3F);
        end
    endtask

    task automatic entity_step(input logic [7:0] c);
        int   n;
        logic prefix;
        logic ok;
        n = ent_fill + 1;
        prefix = 1'b0;
        for (int k = 0; k < 7; k++) begin
            ok = (n <= ent_names[k].len());
            for (int i = 0; ok && i + 1 < n; i++)
                if (ent_buf[i] != ent_names[k][i]) ok = 1'b0;
            if (ok && ent_names[k][n-1] != c) ok = 1'b0;
            if (ok) begin
                if (n == ent_names[k].len()) begin
                    write_text(ent_chars[k]);
                    ent_fill = 0;
                    return;
                end
                prefix = 1'b1;
            end
        end
        if (prefix && n < 6) begin
            ent_buf[n-1] = c;
            ent_fill = n;
            return;
        end
        flush_entity();
        plain_byte(c);
    endtask

    task automatic clear_string();
        after_space = 1'b1;
        committed = 0;
        space_held = 1'b0;
        cp_acc = '0;
        cont_left = 0;
        ent_fill = 0;
        for (int i = 0; i < 6; i++) ent_buf[i] = '0;
    endtask

    // predict the characters caused by one accepted source byte
    task automatic transliterate_byte(input logic [7:0] c);
        if (c == 8'h00) begin
            if (cont_left > 0) map_code_point(cp_acc);
            if (ent_fill > 0) flush_entity();
            push_char(7'h00, 1'b1);
            clear_string();
        end else if (cont_left > 0) begin
            if (c[7:6] == 2'b10) begin
                cp_acc = {cp_acc[14:0], c[5:0]};
                cont_left--;
                if (cont_left == 0) map_code_point(cp_acc);
            end else begin
                cont_left = 0;
                map_code_point(cp_acc);
                plain_byte(c);
            end
        end else if (ent_fill > 0) begin
            entity_step(c);
        end else begin
            plain_byte(c);
        end
    endtask

    // inputs only move at the rising edge, so the falling edge sees each
    // handshake exactly as the next rising edge will take it
    always @(negedge aclk) begin
        logic [7:0] exp_v;
        if (!aresetn) begin
            max_len = 13'd256;
            clear_string();
            expected_chars.delete();
            fail_count = 0;
            chars_seen = 0;
        end else begin
            if (cfg_wr_en) max_len = cfg_wr_data;
            if (s_valid && s_ready) transliterate_byte(s_in_byte);
            if (m_valid && m_ready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transaction: byte %h last %b",
                                 m_out_byte, m_out_last);
                end else begin
                    exp_v = expected_chars.pop_front();
                    if (exp_v[6:0] !== m_out_byte || exp_v[7] !== m_out_last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                                     exp_v[6:0], exp_v[7], m_out_byte, m_out_last);
                    end
                end
            end
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// top of the testbench: clock, reset, stimulus and verdict for the text to ascii block
// depends on utf8_entity_text_to_ascii_top and text_ascii_checker
module testbench;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [12:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        m_valid;
    logic        m_ready;
    logic [6:0]  m_out_byte;
    logic        m_out_last;
    int          fail_count;
    int          pending;
    int          chars_seen;

    int idle_pct;
    int stall_pct;
    int bytes_sent;
    int strings_sent;

    logic [7:0] text_bytes[$];

    logic [20:0] mapped_cps[23] = '{
        21'h2018, 21'h2019, 21'h201B, 21'h2032, 21'h201C, 21'h201D, 21'h2033,
        21'h2010, 21'h2013, 21'h2014, 21'h2212, 21'h2026, 21'h2026, 21'h00A0,
        21'h2009, 21'h200A, 21'h202F, 21'h00E9, 21'h00E1, 21'h00F1, 21'h00E7,
        21'h00FC, 21'h00F5
    };
    string ent_names[7] = '{"&quot;", "&amp;", "&lt;", "&gt;", "&#039;", "&#39;", "&apos;"};
    logic [12:0] len_settings[8] = '{13'd1, 13'd0, 13'd3, 13'd12, 13'd4096,
                                     13'd8191, 13'd40, 13'd256};

    utf8_entity_text_to_ascii_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last)
    );

    text_ascii_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last),
        .fail_count  (fail_count),
        .pending     (pending),
        .chars_seen  (chars_seen)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // one source byte per transaction, with random idle cycles first
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_string();
        foreach (text_bytes[i]) send_byte(text_bytes[i]);
        send_byte(8'h00);
        text_bytes.delete();
        strings_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
    endtask

    task automatic add_utf8(input logic [20:0] cp, input logic cut);
        logic [7:0] seq[$];
        if (cp < 21'h800) begin
            seq = '{8'hC0 | cp[10:6], 8'h80 | cp[5:0]};
        end else if (cp < 21'h10000) begin
            seq = '{8'hE0 | cp[15:12], 8'h80 | cp[11:6], 8'h80 | cp[5:0]};
        end else begin
            seq = '{8'hF0 | cp[20:18], 8'h80 | cp[17:12], 8'h80 | cp[11:6],
                    8'h80 | cp[5:0]};
        end
        if (cut) void'(seq.pop_back());
        foreach (seq[i]) text_bytes.push_back(seq[i]);
    endtask

    // wait until every expected character is out and the pipe has drained
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_len(input logic [12:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // one random token of text: mostly well-formed words, entities, utf-8
    task automatic add_token();
        int    kind;
        string s;
        kind = $urandom_range(99);
        if (kind < 30) begin
            repeat ($urandom_range(1, 4))
                text_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end else if (kind < 45) begin
            repeat ($urandom_range(1, 3))
                case ($urandom_range(3))
                    0: text_bytes.push_back(8'h20);
                    1: text_bytes.push_back(8'h09);
                    2: text_bytes.push_back(8'h0A);
                    default: text_bytes.push_back(8'h0D);
                endcase
        end else if (kind < 62) begin
            s = ent_names[$urandom_range(6)];
            if ($urandom_range(3) == 0) s = s.substr(0, $urandom_range(0, s.len() - 2));
            add_text(s);
        end else if (kind < 80) begin
            add_utf8(mapped_cps[$urandom_range(22)], $urandom_range(7) == 0);
        end else if (kind < 88) begin
            add_utf8(21'($urandom_range(21'h80, 21'h1FFFFF)), $urandom_range(7) == 0);
        end else begin
            text_bytes.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int phase_bytes;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_in_byte = '0;
        m_ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        bytes_sent = 0;
        strings_sent = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: whitespace, entities, ellipsis, no-break space, stray bytes
        add_text("  a&amp;b\t");
        send_string();
        text_bytes = '{8'hE2, 8'h80, 8'hA6, 8'hC2, 8'hA0, 8'h80, 8'h7F, 8'hFF, 8'h41};
        send_string();
        // broken entity, short utf-8 sequence, end inside a sequence
        text_bytes = '{8'h26, 8'h23, 8'h30, 8'h78, 8'hE2, 8'h41, 8'h01, 8'hE2};
        send_string();

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_len(len_settings[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            phase_bytes = bytes_sent + 40;
            while (bytes_sent < phase_bytes) begin
                repeat ($urandom_range(1, 5)) add_token();
                // end inside an entity now and then
                if ($urandom_range(9) == 0) text_bytes.push_back(8'h26);
                // in phase 2, hold off until the block is empty before every third string
                if (ph == 2 && strings_sent % 3 == 0 && pending != 0) begin
                    s_valid <= 1'b0;
                    while (pending != 0) @(posedge aclk);
                end
                send_string();
            end
        end

        drain();
        $display("sent %0d source bytes in %0d strings over 8 length settings, %0d characters out",
                 bytes_sent, strings_sent, chars_seen);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/u8e_pkg.sv
src/u8e_front.sv
src/u8e_queue.sv
src/u8e_back.sv
src/utf8_entity_text_to_ascii_top.sv
tb/sv/text_ascii_checker.sv
tb/sv/testbench.sv
